@@ rtl/cpcr_pkg.sv @@
// cpcr_pkg: shared types, stage counts and step functions of the circle pair
// collision resolver (signed Q16.16 contact response).
// No dependencies; used by the divider, the output buffer and the top level.
package cpcr_pkg;

  localparam int SqrtSteps = 32;
  localparam int DivSteps  = 17;
  // input, square, sum, root steps, axis setup, divide steps, five math stages
  localparam int NumStages = 3 + SqrtSteps + 1 + DivSteps + 5;
  localparam int LastStage = NumStages - 1;

  localparam logic [16:0] ElasticityReset = 17'd65536;
  localparam logic [16:0] OneQ16          = 17'd65536;
  localparam logic [16:0] HalfQ16         = 17'd32768;

  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] avx;
    logic signed [31:0] avy;
    logic signed [31:0] bvx;
    logic signed [31:0] bvy;
  } item_t;

  typedef struct packed {
    item_t       it;
    logic [32:0] adx;
    logic [32:0] ady;
    logic        sdx;
    logic        sdy;
    logic [31:0] rs;
    logic [30:0] ma;
    logic [30:0] mb;
    logic        pre;
  } s0_t;

  typedef struct packed {
    item_t       it;
    logic [31:0] adx;
    logic [31:0] ady;
    logic        sdx;
    logic        sdy;
    logic [31:0] rs;
    logic [30:0] ma;
    logic [30:0] mb;
    logic        pre;
    logic [63:0] sx;
    logic [63:0] sy;
  } s1_t;

  typedef struct packed {
    item_t       it;
    logic [31:0] adx;
    logic [31:0] ady;
    logic        sdx;
    logic        sdy;
    logic [31:0] rs;
    logic [30:0] ma;
    logic [30:0] mb;
    logic        ok;
    logic [63:0] n;
    logic [34:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    item_t       it;
    logic        sdx;
    logic        sdy;
    logic        hit;
    logic        zero;
    logic        tzero;
    logic [31:0] pen;
  } hd_t;

  typedef struct packed {
    item_t              it;
    logic               hit;
    logic signed [17:0] ux;
    logic signed [17:0] uy;
    logic [16:0]        sha;
    logic [16:0]        shb;
    logic [31:0]        pen;
    logic signed [32:0] rvx;
    logic signed [32:0] rvy;
  } x1_t;

  typedef struct packed {
    item_t              it;
    logic               hit;
    logic signed [17:0] ux;
    logic signed [17:0] uy;
    logic signed [50:0] px;
    logic signed [50:0] py;
    logic [31:0]        ta;
    logic [31:0]        tb;
    logic [18:0]        ka;
    logic [18:0]        kb;
  } x2_t;

  typedef struct packed {
    item_t              it;
    logic               hit;
    logic signed [17:0] ux;
    logic signed [17:0] uy;
    logic signed [35:0] imp;
    logic [31:0]        ta;
    logic [31:0]        tb;
    logic [18:0]        ka;
    logic [18:0]        kb;
  } x3_t;

  typedef struct packed {
    item_t              it;
    logic               hit;
    logic signed [17:0] ux;
    logic signed [17:0] uy;
    logic signed [39:0] ja;
    logic signed [39:0] jb;
    logic signed [34:0] oax;
    logic signed [34:0] oay;
    logic signed [34:0] obx;
    logic signed [34:0] oby;
  } x4_t;

  typedef struct packed {
    item_t              it;
    logic               hit;
    logic signed [41:0] vax;
    logic signed [41:0] vay;
    logic signed [41:0] vbx;
    logic signed [41:0] vby;
  } x5_t;

  typedef struct packed {
    item_t it;
    logic  hit;
  } res_t;

  function automatic logic signed [31:0] sat32(logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -48'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // one result bit of the integer square root, two radicand bits per step
  function automatic sq_t sqrt_step(sq_t s, logic [1:0] pr);
    sq_t         o;
    logic [34:0] rsh;
    logic [34:0] tr;
    o   = s;
    rsh = {s.rem[32:0], pr};
    tr  = {1'b0, s.root, 2'b01};
    if (rsh >= tr) begin
      o.rem  = rsh - tr;
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = rsh;
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  // restoring divide step: returns {quotient bit, new remainder}
  function automatic logic [32:0] div_step(logic [31:0] rem, logic b, logic [31:0] den);
    logic [32:0] tr;
    logic [32:0] diff;
    logic [32:0] r;
    tr   = {rem, b};
    diff = tr - {1'b0, den};
    if (tr >= {1'b0, den}) begin
      r = {1'b1, diff[31:0]};
    end else begin
      r = {1'b0, tr[31:0]};
    end
    return r;
  endfunction

endpackage

@@ rtl/cpcr_ifs.sv @@
// cpcr_pair_if and cpcr_result_if: valid/ready channels of the collision
// resolver, one circle pair in and one resolved pair out per transfer.
// No dependencies.
interface cpcr_pair_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic signed [31:0] a_vx;
  logic signed [31:0] a_vy;
  logic signed [31:0] b_vx;
  logic signed [31:0] b_vy;
  logic [30:0]        a_radius;
  logic [30:0]        b_radius;
  logic [30:0]        a_mass;
  logic [30:0]        b_mass;

  modport source(output valid, a_x, a_y, b_x, b_y, a_vx, a_vy, b_vx, b_vy,
                 a_radius, b_radius, a_mass, b_mass, input ready);
  modport sink(input valid, a_x, a_y, b_x, b_y, a_vx, a_vy, b_vx, b_vy,
               a_radius, b_radius, a_mass, b_mass, output ready);
endinterface

interface cpcr_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_a_x;
  logic signed [31:0] new_a_y;
  logic signed [31:0] new_b_x;
  logic signed [31:0] new_b_y;
  logic signed [31:0] new_a_vx;
  logic signed [31:0] new_a_vy;
  logic signed [31:0] new_b_vx;
  logic signed [31:0] new_b_vy;
  logic               hit;

  modport source(output valid, new_a_x, new_a_y, new_b_x, new_b_y, new_a_vx,
                 new_a_vy, new_b_vx, new_b_vy, hit, input ready);
  modport sink(input valid, new_a_x, new_a_y, new_b_x, new_b_y, new_a_vx,
               new_a_vy, new_b_vx, new_b_vy, hit, output ready);
endinterface

@@ rtl/cpcr_udiv_pipe.sv @@
// cpcr_udiv_pipe: pipelined restoring divider, 48-bit dividend by 32-bit
// divisor, 17 quotient bits, one bit per register stage.
// Depends on cpcr_pkg (div_step, DivSteps).
module cpcr_udiv_pipe (
  input  logic        clk,
  input  logic        en,
  input  logic [47:0] num,
  input  logic [31:0] den,
  output logic [16:0] quo
);

  logic [31:0] rem [cpcr_pkg::DivSteps];
  logic [16:0] lo  [cpcr_pkg::DivSteps];
  logic [31:0] dd  [cpcr_pkg::DivSteps];
  logic [16:0] q   [cpcr_pkg::DivSteps];

  logic [32:0] first;
  assign first = cpcr_pkg::div_step({1'b0, num[47:17]}, num[16], den);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= first[31:0];
      lo[0]  <= num[16:0];
      dd[0]  <= den;
      q[0]   <= {16'd0, first[32]};
    end
  end

  for (genvar k = 1; k < cpcr_pkg::DivSteps; k++) begin : g_step
    logic [32:0] st;
    assign st = cpcr_pkg::div_step(rem[k-1], lo[k-1][cpcr_pkg::DivSteps-1-k], dd[k-1]);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= st[31:0];
        lo[k]  <= lo[k-1];
        dd[k]  <= dd[k-1];
        q[k]   <= {q[k-1][15:0], st[32]};
      end
    end
  end

  assign quo = q[cpcr_pkg::DivSteps-1];

endmodule

@@ rtl/cpcr_out_buf.sv @@
// cpcr_out_buf: two-entry result buffer between the pipeline and the result
// channel, so the pipeline keeps moving while one result waits.
// Depends on cpcr_pkg (res_t).
module cpcr_out_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cpcr_pkg::res_t push_data,
  input  logic           pop,
  output logic           full,
  output logic           valid,
  output cpcr_pkg::res_t data
);

  cpcr_pkg::res_t mem [2];
  logic [1:0]     count;
  logic           head;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      head  <= 1'b0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
      if (pop) begin
        head <= ~head;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[head ^ count[0]] <= push_data;
    end
  end

  assign full  = count[1];
  assign valid = (count != 2'd0);
  assign data  = mem[head];

endmodule

@@ rtl/circle_pair_collision_resolve_core.sv @@
// Circle pair collision resolver. Takes one circle pair per cycle while the
// result buffer has room and resolves it in a 58-stage pipeline (input,
// squaring, radicand sum, 32 square-root steps, axis setup, 17 divide steps
// for the unit axis and the mass share, five arithmetic stages) that feeds a
// two-entry result buffer. The sustained rate is one pair per cycle, set by
// the pipeline that advances whenever the buffer has room. Elasticity is
// written through elasticity_we/elasticity_wdata while the block is idle; the
// block itself does not enforce this. It resets to one (65536).
module circle_pair_collision_resolve_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 elasticity_we,
  input  logic [16:0]          elasticity_wdata,
  cpcr_pair_if.sink            pair,
  cpcr_result_if.source        result
);

  logic [16:0] elasticity;

  always_ff @(posedge clk) begin
    if (rst) begin
      elasticity <= cpcr_pkg::ElasticityReset;
    end else if (elasticity_we) begin
      elasticity <= elasticity_wdata;
    end
  end

  logic                      en;
  logic                      buf_full;
  logic [cpcr_pkg::NumStages-1:0] v;

  assign en         = ~buf_full;
  assign pair.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[cpcr_pkg::NumStages-2:0], pair.valid};
    end
  end

  // stage 0: differences, magnitudes, radius sum
  cpcr_pkg::s0_t     s0, s0_next;
  logic signed [32:0] dx, dy;

  always_comb begin
    s0_next.it.ax  = pair.a_x;
    s0_next.it.ay  = pair.a_y;
    s0_next.it.bx  = pair.b_x;
    s0_next.it.by  = pair.b_y;
    s0_next.it.avx = pair.a_vx;
    s0_next.it.avy = pair.a_vy;
    s0_next.it.bvx = pair.b_vx;
    s0_next.it.bvy = pair.b_vy;
    dx = 33'(pair.a_x) - 33'(pair.b_x);
    dy = 33'(pair.a_y) - 33'(pair.b_y);
    s0_next.sdx = dx[32];
    s0_next.sdy = dy[32];
    s0_next.adx = dx[32] ? 33'(-dx) : 33'(dx);
    s0_next.ady = dy[32] ? 33'(-dy) : 33'(dy);
    s0_next.rs  = {1'b0, pair.a_radius} + {1'b0, pair.b_radius};
    s0_next.ma  = pair.a_mass;
    s0_next.mb  = pair.b_mass;
    s0_next.pre = (s0_next.adx < {1'b0, s0_next.rs}) && (s0_next.ady < {1'b0, s0_next.rs});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0 <= s0_next;
    end
  end

  // stage 1: squares
  cpcr_pkg::s1_t s1;

  always_ff @(posedge clk) begin
    if (en) begin
      s1.it  <= s0.it;
      s1.adx <= s0.adx[31:0];
      s1.ady <= s0.ady[31:0];
      s1.sdx <= s0.sdx;
      s1.sdy <= s0.sdy;
      s1.rs  <= s0.rs;
      s1.ma  <= s0.ma;
      s1.mb  <= s0.mb;
      s1.pre <= s0.pre;
      s1.sx  <= s0.adx[31:0] * s0.adx[31:0];
      s1.sy  <= s0.ady[31:0] * s0.ady[31:0];
    end
  end

  // stage 2 and the square-root steps; entry 0 holds the radicand
  cpcr_pkg::sq_t sq [cpcr_pkg::SqrtSteps+1];
  logic [64:0]   sum2;

  assign sum2 = {1'b0, s1.sx} + {1'b0, s1.sy};

  always_ff @(posedge clk) begin
    if (en) begin
      sq[0].it   <= s1.it;
      sq[0].adx  <= s1.adx;
      sq[0].ady  <= s1.ady;
      sq[0].sdx  <= s1.sdx;
      sq[0].sdy  <= s1.sdy;
      sq[0].rs   <= s1.rs;
      sq[0].ma   <= s1.ma;
      sq[0].mb   <= s1.mb;
      sq[0].ok   <= s1.pre & ~sum2[64];
      sq[0].n    <= sum2[63:0];
      sq[0].rem  <= '0;
      sq[0].root <= '0;
    end
  end

  for (genvar k = 1; k <= cpcr_pkg::SqrtSteps; k++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (en) begin
        sq[k] <= cpcr_pkg::sqrt_step(sq[k-1],
                                     sq[k-1].n[2*(cpcr_pkg::SqrtSteps-k) +: 2]);
      end
    end
  end

  // axis setup: hit test, penetration, divider operands
  cpcr_pkg::hd_t hd;
  logic [47:0]   h_nx, h_ny, h_nm;
  logic [31:0]   h_dist, h_tot;
  cpcr_pkg::sq_t sl;
  logic [31:0]   tot;

  assign sl  = sq[cpcr_pkg::SqrtSteps];
  assign tot = {1'b0, sl.ma} + {1'b0, sl.mb};

  always_ff @(posedge clk) begin
    if (en) begin
      hd.it    <= sl.it;
      hd.sdx   <= sl.sdx;
      hd.sdy   <= sl.sdy;
      hd.hit   <= sl.ok && (sl.root < sl.rs);
      hd.zero  <= (sl.root == 32'd0);
      hd.tzero <= (tot == 32'd0);
      hd.pen   <= sl.rs - sl.root;
      h_nx     <= {sl.adx, 16'd0};
      h_ny     <= {sl.ady, 16'd0};
      h_nm     <= {1'b0, sl.mb, 16'd0};
      h_dist   <= sl.root;
      h_tot    <= tot;
    end
  end

  logic [16:0] qx, qy, qm;

  cpcr_udiv_pipe u_div_x (.clk(clk), .en(en), .num(h_nx), .den(h_dist), .quo(qx));
  cpcr_udiv_pipe u_div_y (.clk(clk), .en(en), .num(h_ny), .den(h_dist), .quo(qy));
  cpcr_udiv_pipe u_div_m (.clk(clk), .en(en), .num(h_nm), .den(h_tot),  .quo(qm));

  cpcr_pkg::hd_t dv [cpcr_pkg::DivSteps];

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0] <= hd;
    end
  end

  for (genvar k = 1; k < cpcr_pkg::DivSteps; k++) begin : g_dv
    always_ff @(posedge clk) begin
      if (en) begin
        dv[k] <= dv[k-1];
      end
    end
  end

  // x1: signed unit axis, mass shares, relative velocity
  cpcr_pkg::x1_t x1, x1_next;
  cpcr_pkg::hd_t dl;

  assign dl = dv[cpcr_pkg::DivSteps-1];

  always_comb begin
    x1_next.it  = dl.it;
    x1_next.hit = dl.hit;
    x1_next.pen = dl.pen;
    if (dl.zero) begin
      x1_next.ux = $signed({1'b0, cpcr_pkg::OneQ16});
      x1_next.uy = '0;
    end else begin
      x1_next.ux = dl.sdx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
      x1_next.uy = dl.sdy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    end
    x1_next.sha = dl.tzero ? cpcr_pkg::HalfQ16 : qm;
    x1_next.shb = cpcr_pkg::OneQ16 - x1_next.sha;
    x1_next.rvx = 33'(dl.it.avx) - 33'(dl.it.bvx);
    x1_next.rvy = 33'(dl.it.avy) - 33'(dl.it.bvy);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= x1_next;
    end
  end

  // x2: impulse products, position shifts, velocity gains
  cpcr_pkg::x2_t x2, x2_next;
  logic [48:0]   ma_p, mb_p;
  logic [34:0]   ka_p, kb_p;

  always_comb begin
    x2_next.it  = x1.it;
    x2_next.hit = x1.hit;
    x2_next.ux  = x1.ux;
    x2_next.uy  = x1.uy;
    x2_next.px  = x1.rvx * x1.ux;
    x2_next.py  = x1.rvy * x1.uy;
    ma_p = x1.sha * x1.pen;
    mb_p = x1.shb * x1.pen;
    x2_next.ta = ma_p[47:16];
    x2_next.tb = mb_p[47:16];
    ka_p = {elasticity, 1'b0} * x1.sha;
    kb_p = {elasticity, 1'b0} * x1.shb;
    x2_next.ka = ka_p[34:16];
    x2_next.kb = kb_p[34:16];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2 <= x2_next;
    end
  end

  // x3: impulse
  cpcr_pkg::x3_t      x3, x3_next;
  logic signed [51:0] isum;

  always_comb begin
    x3_next.it  = x2.it;
    x3_next.hit = x2.hit;
    x3_next.ux  = x2.ux;
    x3_next.uy  = x2.uy;
    isum = 52'(x2.px) + 52'(x2.py);
    x3_next.imp = isum[51:16];
    x3_next.ta  = x2.ta;
    x3_next.tb  = x2.tb;
    x3_next.ka  = x2.ka;
    x3_next.kb  = x2.kb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x3 <= x3_next;
    end
  end

  // x4: velocity magnitudes and position offsets
  cpcr_pkg::x4_t      x4, x4_next;
  logic signed [55:0] ja_p, jb_p;
  logic signed [50:0] oax_p, oay_p, obx_p, oby_p;

  always_comb begin
    x4_next.it  = x3.it;
    x4_next.hit = x3.hit;
    x4_next.ux  = x3.ux;
    x4_next.uy  = x3.uy;
    ja_p  = $signed({1'b0, x3.ka}) * x3.imp;
    jb_p  = $signed({1'b0, x3.kb}) * x3.imp;
    oax_p = x3.ux * $signed({1'b0, x3.ta});
    oay_p = x3.uy * $signed({1'b0, x3.ta});
    obx_p = x3.ux * $signed({1'b0, x3.tb});
    oby_p = x3.uy * $signed({1'b0, x3.tb});
    x4_next.ja  = ja_p[55:16];
    x4_next.jb  = jb_p[55:16];
    x4_next.oax = oax_p[50:16];
    x4_next.oay = oay_p[50:16];
    x4_next.obx = obx_p[50:16];
    x4_next.oby = oby_p[50:16];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x4 <= x4_next;
    end
  end

  // x5: resolved positions, velocity offsets
  cpcr_pkg::x5_t      x5, x5_next;
  logic signed [57:0] vax_p, vay_p, vbx_p, vby_p;

  always_comb begin
    x5_next.it  = x4.it;
    x5_next.hit = x4.hit;
    if (x4.hit) begin
      x5_next.it.ax = cpcr_pkg::sat32(48'(x4.it.ax) + 48'(x4.oax));
      x5_next.it.ay = cpcr_pkg::sat32(48'(x4.it.ay) + 48'(x4.oay));
      x5_next.it.bx = cpcr_pkg::sat32(48'(x4.it.bx) - 48'(x4.obx));
      x5_next.it.by = cpcr_pkg::sat32(48'(x4.it.by) - 48'(x4.oby));
    end
    vax_p = x4.ux * x4.ja;
    vay_p = x4.uy * x4.ja;
    vbx_p = x4.ux * x4.jb;
    vby_p = x4.uy * x4.jb;
    x5_next.vax = vax_p[57:16];
    x5_next.vay = vay_p[57:16];
    x5_next.vbx = vbx_p[57:16];
    x5_next.vby = vby_p[57:16];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x5 <= x5_next;
    end
  end

  // resolved velocities go straight into the result buffer
  cpcr_pkg::res_t res_next, res_head;
  logic           buf_valid;
  logic           push;

  always_comb begin
    res_next.it  = x5.it;
    res_next.hit = x5.hit;
    if (x5.hit) begin
      res_next.it.avx = cpcr_pkg::sat32(48'(x5.it.avx) - 48'(x5.vax));
      res_next.it.avy = cpcr_pkg::sat32(48'(x5.it.avy) - 48'(x5.vay));
      res_next.it.bvx = cpcr_pkg::sat32(48'(x5.it.bvx) + 48'(x5.vbx));
      res_next.it.bvy = cpcr_pkg::sat32(48'(x5.it.bvy) + 48'(x5.vby));
    end
  end

  assign push = en & v[cpcr_pkg::LastStage];

  cpcr_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(res_next),
    .pop      (result.valid & result.ready),
    .full     (buf_full),
    .valid    (buf_valid),
    .data     (res_head)
  );

  assign result.valid    = buf_valid;
  assign result.new_a_x  = res_head.it.ax;
  assign result.new_a_y  = res_head.it.ay;
  assign result.new_b_x  = res_head.it.bx;
  assign result.new_b_y  = res_head.it.by;
  assign result.new_a_vx = res_head.it.avx;
  assign result.new_a_vy = res_head.it.avy;
  assign result.new_b_vx = res_head.it.bvx;
  assign result.new_b_vy = res_head.it.bvy;
  assign result.hit      = res_head.hit;

  // a hit always leaves a nonzero penetration depth
  a_hit_pen: assert property (@(posedge clk) disable iff (rst)
    (v[cpcr_pkg::SqrtSteps+3] && hd.hit) |-> (hd.pen != 32'd0))
    else $error("hit with zero penetration");

  // an item in the last divide stage reaches x1 on the next advance
  a_div_align: assert property (@(posedge clk) disable iff (rst)
    (en && v[cpcr_pkg::SqrtSteps+3+cpcr_pkg::DivSteps]) |=>
    v[cpcr_pkg::SqrtSteps+4+cpcr_pkg::DivSteps])
    else $error("valid lost across divider");

  // while stalled, no item leaves the last stage
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!en && v[cpcr_pkg::LastStage]) |=> v[cpcr_pkg::LastStage])
    else $error("item dropped during stall");

endmodule
